>>> hdl/ps2hcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hcs_pkg
// Shared types, codes and constants of the PS/2 host command sequencer.
// ----------------------------------------------------------------------------
package ps2hcs_pkg;

    // default command queue depth
    localparam int QUEUE_DEPTH_DEF = 32;

    // depth of the word queue between front and back, and of the result queue
    localparam int FRONT_DEPTH = 2;
    localparam int RES_DEPTH   = 2;

    // retry limit after reset
    localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

    // device protocol bytes
    localparam logic [7:0] B_ACK     = 8'hFA;
    localparam logic [7:0] B_RESEND  = 8'hFE;
    localparam logic [7:0] B_ECHO    = 8'hEE;
    localparam logic [7:0] B_SETLED  = 8'hED;
    localparam logic [7:0] B_NUMLOCK = 8'h45;

    // numlock bit of the led state
    localparam logic [2:0] LED_NUM = 3'b010;

    // operation of an input word
    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_RX   = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    // class of a received byte
    typedef enum logic [2:0] {
        RX_ACK     = 3'd0,
        RX_RESEND  = 3'd1,
        RX_ECHO    = 3'd2,
        RX_ZERO    = 3'd3,
        RX_NUMLOCK = 3'd4,
        RX_OTHER   = 3'd5
    } rx_cls_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_TX   = 3'd0,
        KIND_FWD  = 3'd1,
        KIND_DONE = 3'd2,
        KIND_FAIL = 3'd3,
        KIND_FULL = 3'd4
    } kind_t;

    // phase of the command at the head of the queue
    typedef enum logic [2:0] {
        PH_READY      = 3'd0,
        PH_TRIGGERED  = 3'd1,
        PH_CONFIRMED  = 3'd2,
        PH_AWAIT_ACK  = 3'd3,
        PH_AWAIT_DATA = 3'd4
    } phase_t;

    // classified input word
    typedef struct packed {
        op_t        op;
        rx_cls_t    rx_cls;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       two_byte;
        logic       wait_data;
        logic [7:0] rx_byte;
        logic       tx_ready;
    } item_t;

    // command queue entry
    typedef struct packed {
        logic       wait_data;
        logic       two_byte;
        logic [7:0] second_byte;
        logic [7:0] first_byte;
    } entry_t;

    // result word
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    // build a result word, not yet marked last
    function automatic result_t mk_res(input kind_t k, input logic [7:0] d);
        result_t r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

>>> hdl/ps2_host_command_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_host_command_sequencer
// Host side of the PS/2 device command handshake with a command queue.
// ----------------------------------------------------------------------------
// Words enter through a two-entry input queue (push/full) and results leave
// through a two-entry result queue (empty/pop), so both sides stall on their
// own. The back end executes one input word per clock cycle unless a second
// result is pending or the result queue is full; a word with two results
// (forward plus transmit, forward plus queue full, forward plus fail) holds
// the back end while its second result waits in a pending register. With
// pop held high, single-result words flow at one word per cycle. The command
// queue is a QUEUE_DEPTH-entry memory whose head entry is kept in a register
// and refetched when the head retires; it needs no clearing after reset.
// cfg_wdata sets the retry limit (reset 3); the user is to write it only
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module ps2_host_command_sequencer
#(
    parameter int QUEUE_DEPTH = ps2hcs_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] cmd,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    input  logic       two_byte,
    input  logic       wait_data,
    input  logic [7:0] rx_byte,
    input  logic       tx_ready,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] kind,
    output logic [7:0] out_data,
    output logic       last
);

    logic                item_valid;
    ps2hcs_pkg::item_t   item;
    logic                item_take;
    logic                res_full;
    logic                res_we;
    ps2hcs_pkg::result_t res_word;
    ps2hcs_pkg::result_t head_word;

    // input queue and classification
    ps2hcs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .two_byte    (two_byte),
        .wait_data   (wait_data),
        .rx_byte     (rx_byte),
        .tx_ready    (tx_ready),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    // command execution
    ps2hcs_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_full   (res_full),
        .res_we     (res_we),
        .res_word   (res_word)
    );

    // result queue
    ps2hcs_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_we    (res_we),
        .res_word  (res_word),
        .res_full  (res_full),
        .empty     (empty),
        .pop       (pop),
        .head_word (head_word)
    );

    // result fields
    assign kind     = head_word.kind;
    assign out_data = head_word.data;
    assign last     = head_word.last;

endmodule

>>> hdl/ps2hcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hcs_front
// Input side: accepts words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module ps2hcs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          cmd,
    input  logic [7:0]          first_byte,
    input  logic [7:0]          second_byte,
    input  logic                two_byte,
    input  logic                wait_data,
    input  logic [7:0]          rx_byte,
    input  logic                tx_ready,
    output logic                item_valid,
    output ps2hcs_pkg::item_t   item,
    input  logic                item_take
);

    localparam int DEPTH = ps2hcs_pkg::FRONT_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ps2hcs_pkg::item_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               accept;
    logic               store;
    ps2hcs_pkg::item_t  word;

    // classify the incoming word
    always_comb
    begin
        word.first_byte  = first_byte;
        word.second_byte = second_byte;
        word.two_byte    = two_byte;
        word.wait_data   = wait_data;
        word.rx_byte     = rx_byte;
        word.tx_ready    = tx_ready;
        word.op          = ps2hcs_pkg::OP_TICK;
        store            = 1'b1;
        case (cmd)
            ps2hcs_pkg::OP_ENQ:  word.op = ps2hcs_pkg::OP_ENQ;
            ps2hcs_pkg::OP_RX:   word.op = ps2hcs_pkg::OP_RX;
            ps2hcs_pkg::OP_TICK: word.op = ps2hcs_pkg::OP_TICK;
            default:             store = 1'b0;
        endcase
        if (rx_byte == ps2hcs_pkg::B_ACK)
            word.rx_cls = ps2hcs_pkg::RX_ACK;
        else if (rx_byte == ps2hcs_pkg::B_RESEND)
            word.rx_cls = ps2hcs_pkg::RX_RESEND;
        else if (rx_byte == ps2hcs_pkg::B_ECHO)
            word.rx_cls = ps2hcs_pkg::RX_ECHO;
        else if (rx_byte == 8'h00)
            word.rx_cls = ps2hcs_pkg::RX_ZERO;
        else if (rx_byte == ps2hcs_pkg::B_NUMLOCK)
            word.rx_cls = ps2hcs_pkg::RX_NUMLOCK;
        else
            word.rx_cls = ps2hcs_pkg::RX_OTHER;
    end

    // queue control, unused command codes are taken and dropped
    assign full       = (count_reg == CNT_FULL);
    assign accept     = push && !full && store;
    assign item_valid = (count_reg != '0);
    assign item       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (item_take && item_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !(item_take && item_valid))
            count_next = count_reg + 1'b1;
        else if (!accept && item_take && item_valid)
            count_next = count_reg - 1'b1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (accept)
            slot_reg[wr_ptr_reg] <= word;
    end

endmodule

>>> hdl/ps2hcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hcs_back
// Execution side: command queue, head phase and retry handling, result words.
// ----------------------------------------------------------------------------
module ps2hcs_back
#(
    parameter int QUEUE_DEPTH = ps2hcs_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata,
    input  logic                item_valid,
    input  ps2hcs_pkg::item_t   item,
    output logic                item_take,
    input  logic                res_full,
    output logic                res_we,
    output ps2hcs_pkg::result_t res_word
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // command queue memory and its registered head entry
    ps2hcs_pkg::entry_t  mem [QUEUE_DEPTH];
    ps2hcs_pkg::entry_t  head_ent_reg;

    logic [PTR_W-1:0]    head_ptr_reg;
    logic [PTR_W-1:0]    head_ptr_next;
    logic [PTR_W-1:0]    tail_ptr_reg;
    logic [PTR_W-1:0]    tail_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    ps2hcs_pkg::phase_t  phase_reg;
    ps2hcs_pkg::phase_t  phase_next;
    logic [3:0]          retry_reg;
    logic [3:0]          retry_next;
    logic [2:0]          led_reg;
    logic [2:0]          led_next;
    logic [3:0]          limit_reg;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    ps2hcs_pkg::result_t pend_reg;

    logic [1:0]          res_n;
    ps2hcs_pkg::result_t res0;
    ps2hcs_pkg::result_t res1;
    logic                wr_en;
    ps2hcs_pkg::entry_t  wr_data;
    logic                pop_q;
    logic                head_load;
    logic                do_kick;
    logic                do_fin;
    logic                fwd;
    ps2hcs_pkg::kind_t   fin_kind;
    logic [7:0]          fin_data;
    ps2hcs_pkg::entry_t  he;
    logic [2:0]          nl;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // one word a cycle unless a second result is still pending or the result queue is full
    assign item_take = item_valid && !pend_valid_reg && !res_full;

    // step of the sequencer for the word at the front
    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        retry_next    = retry_reg;
        led_next      = led_reg;
        he            = head_ent_reg;
        res_n         = 2'd0;
        res0          = ps2hcs_pkg::mk_res(ps2hcs_pkg::KIND_TX, 8'h00);
        res1          = ps2hcs_pkg::mk_res(ps2hcs_pkg::KIND_TX, 8'h00);
        wr_en         = 1'b0;
        wr_data.first_byte  = item.first_byte;
        wr_data.second_byte = item.second_byte;
        wr_data.two_byte    = item.two_byte;
        wr_data.wait_data   = item.wait_data;
        pop_q         = 1'b0;
        head_load     = 1'b0;
        do_kick       = 1'b0;
        do_fin        = 1'b0;
        fwd           = 1'b0;
        fin_kind      = ps2hcs_pkg::KIND_DONE;
        fin_data      = 8'h00;
        nl            = led_reg ^ ps2hcs_pkg::LED_NUM;

        // decode by operation and head phase
        case (item.op)
            ps2hcs_pkg::OP_ENQ:
            begin
                if (count_next == CNT_FULL)
                begin
                    res0  = ps2hcs_pkg::mk_res(ps2hcs_pkg::KIND_FULL, item.first_byte);
                    res_n = 2'd1;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (count_next == '0)
                    begin
                        he        = wr_data;
                        head_load = 1'b1;
                    end
                    tail_ptr_next = ptr_inc(tail_ptr_next);
                    count_next    = count_next + 1'b1;
                    do_kick       = 1'b1;
                end
            end
            ps2hcs_pkg::OP_RX:
            begin
                if (count_next == '0)
                    fwd = 1'b1;
                else
                begin
                    case (phase_next)
                        ps2hcs_pkg::PH_TRIGGERED:
                        begin
                            case (item.rx_cls)
                                ps2hcs_pkg::RX_ACK:
                                begin
                                    phase_next = ps2hcs_pkg::PH_CONFIRMED;
                                    if (he.two_byte)
                                        do_kick = 1'b1;
                                    else if (he.wait_data)
                                        phase_next = ps2hcs_pkg::PH_AWAIT_DATA;
                                    else
                                    begin
                                        do_fin   = 1'b1;
                                        fin_kind = ps2hcs_pkg::KIND_DONE;
                                        fin_data = ps2hcs_pkg::B_ACK;
                                    end
                                end
                                ps2hcs_pkg::RX_RESEND:
                                begin
                                    phase_next = ps2hcs_pkg::PH_READY;
                                    do_kick    = 1'b1;
                                end
                                ps2hcs_pkg::RX_ECHO:
                                begin
                                    do_fin   = 1'b1;
                                    fin_kind = ps2hcs_pkg::KIND_DONE;
                                    fin_data = ps2hcs_pkg::B_ECHO;
                                end
                                ps2hcs_pkg::RX_ZERO:
                                begin
                                    do_fin   = 1'b1;
                                    fin_kind = ps2hcs_pkg::KIND_FAIL;
                                    fin_data = he.first_byte;
                                end
                                default: fwd = 1'b1;
                            endcase
                        end
                        ps2hcs_pkg::PH_AWAIT_ACK:
                        begin
                            if (item.rx_cls != ps2hcs_pkg::RX_ACK)
                            begin
                                do_fin   = 1'b1;
                                fin_kind = ps2hcs_pkg::KIND_FAIL;
                                fin_data = he.first_byte;
                            end
                            else if (he.wait_data)
                                phase_next = ps2hcs_pkg::PH_AWAIT_DATA;
                            else
                            begin
                                do_fin   = 1'b1;
                                fin_kind = ps2hcs_pkg::KIND_DONE;
                                fin_data = ps2hcs_pkg::B_ACK;
                            end
                        end
                        ps2hcs_pkg::PH_AWAIT_DATA:
                        begin
                            do_fin   = 1'b1;
                            fin_kind = ps2hcs_pkg::KIND_DONE;
                            fin_data = item.rx_byte;
                        end
                        default: fwd = 1'b1;
                    endcase
                end
            end
            ps2hcs_pkg::OP_TICK: do_kick = 1'b1;
            default: ;
        endcase

        // forward a scancode, numlock queues a set-led command
        if (fwd)
        begin
            res0  = ps2hcs_pkg::mk_res(ps2hcs_pkg::KIND_FWD, item.rx_byte);
            res_n = 2'd1;
            if (item.rx_cls == ps2hcs_pkg::RX_NUMLOCK)
            begin
                if (count_next == CNT_FULL)
                begin
                    res1  = ps2hcs_pkg::mk_res(ps2hcs_pkg::KIND_FULL, ps2hcs_pkg::B_SETLED);
                    res_n = 2'd2;
                end
                else
                begin
                    wr_en               = 1'b1;
                    wr_data.first_byte  = ps2hcs_pkg::B_SETLED;
                    wr_data.second_byte = {5'b00000, nl};
                    wr_data.two_byte    = 1'b1;
                    wr_data.wait_data   = 1'b0;
                    if (count_next == '0)
                    begin
                        he        = wr_data;
                        head_load = 1'b1;
                    end
                    tail_ptr_next = ptr_inc(tail_ptr_next);
                    count_next    = count_next + 1'b1;
                    led_next      = nl;
                    do_kick       = 1'b1;
                end
            end
        end

        // try the pending write of the head command
        if (do_kick && (count_next != '0) &&
            (phase_next == ps2hcs_pkg::PH_READY || phase_next == ps2hcs_pkg::PH_CONFIRMED))
        begin
            if (item.tx_ready)
            begin
                if (res_n == 2'd0)
                    res0 = ps2hcs_pkg::mk_res(ps2hcs_pkg::KIND_TX,
                        (phase_next == ps2hcs_pkg::PH_READY) ? he.first_byte : he.second_byte);
                else
                    res1 = ps2hcs_pkg::mk_res(ps2hcs_pkg::KIND_TX,
                        (phase_next == ps2hcs_pkg::PH_READY) ? he.first_byte : he.second_byte);
                res_n      = res_n + 2'd1;
                phase_next = (phase_next == ps2hcs_pkg::PH_READY) ?
                             ps2hcs_pkg::PH_TRIGGERED : ps2hcs_pkg::PH_AWAIT_ACK;
            end
            else if (retry_next >= limit_reg)
            begin
                do_fin   = 1'b1;
                fin_kind = ps2hcs_pkg::KIND_FAIL;
                fin_data = he.first_byte;
            end
            else
                retry_next = retry_next + 4'd1;
        end

        // retire the head command
        if (do_fin)
        begin
            if (count_next != '0)
            begin
                head_ptr_next = ptr_inc(head_ptr_next);
                count_next    = count_next - 1'b1;
                pop_q         = 1'b1;
            end
            phase_next = ps2hcs_pkg::PH_READY;
            retry_next = 4'd0;
            if (res_n == 2'd0)
                res0 = ps2hcs_pkg::mk_res(fin_kind, fin_data);
            else
                res1 = ps2hcs_pkg::mk_res(fin_kind, fin_data);
            res_n = res_n + 2'd1;
        end

        // mark the final result of this word
        if (res_n == 2'd1)
            res0.last = 1'b1;
        else if (res_n == 2'd2)
            res1.last = 1'b1;
    end

    // result words toward the result queue, second one waits in the pending register
    assign res_we   = !res_full && (pend_valid_reg || (item_take && res_n != 2'd0));
    assign res_word = pend_valid_reg ? pend_reg : res0;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (!res_full)
        begin
            if (pend_valid_reg)
                pend_valid_next = 1'b0;
            else if (item_take && res_n == 2'd2)
                pend_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg   <= '0;
            tail_ptr_reg   <= '0;
            count_reg      <= '0;
            phase_reg      <= ps2hcs_pkg::PH_READY;
            retry_reg      <= 4'd0;
            led_reg        <= 3'd0;
            limit_reg      <= ps2hcs_pkg::RETRY_LIMIT_RST;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                head_ptr_reg <= head_ptr_next;
                tail_ptr_reg <= tail_ptr_next;
                count_reg    <= count_next;
                phase_reg    <= phase_next;
                retry_reg    <= retry_next;
                led_reg      <= led_next;
            end
            if (cfg_we)
                limit_reg <= cfg_wdata;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // queue memory, head entry read with write bypass
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            if (wr_en)
                mem[tail_ptr_reg] <= wr_data;
            if (pop_q)
                head_ent_reg <= (wr_en && tail_ptr_reg == head_ptr_next) ?
                                wr_data : mem[head_ptr_next];
            else if (head_load)
                head_ent_reg <= he;
            pend_reg <= res1;
        end
    end

endmodule

>>> hdl/ps2hcs_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hcs_out
// Result queue: holds result words until the driver pops them.
// ----------------------------------------------------------------------------
module ps2hcs_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_we,
    input  ps2hcs_pkg::result_t res_word,
    output logic                res_full,
    output logic                empty,
    input  logic                pop,
    output ps2hcs_pkg::result_t head_word
);

    localparam int DEPTH = ps2hcs_pkg::RES_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ps2hcs_pkg::result_t slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                rd_en;

    // status and head word
    assign res_full  = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign rd_en     = pop && !empty;
    assign head_word = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (res_we)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (res_we && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!res_we && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (res_we)
            slot_reg[wr_ptr_reg] <= res_word;
    end

endmodule
